// File: src/swm_pkg.sv
package swm_pkg;

  // sample index width, indices wrap modulo 2^16
  localparam int unsigned IDX_W = 16;
  // width of the window size register
  localparam int unsigned CFG_W = 7;

  // per-cycle command broadcast to every cell of the queue
  typedef struct packed {
    logic step;   // take in the held item: drop from the back, append
    logic pop;    // shift the queue one place toward the front
    logic clear;  // the held item starts a new sequence, queue reads empty
  } cell_op_t;

endpackage

// File: src/swm_cell.sv
module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_pkg::cell_op_t              op_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [swm_pkg::IDX_W-1:0]      idx_i,
  // neighbor toward the back of the queue
  input  logic                           nb_vld_i,
  input  logic signed [SAMPLE_WIDTH-1:0] nb_val_i,
  input  logic [swm_pkg::IDX_W-1:0]      nb_idx_i,
  // neighbor toward the front keeps its entry
  input  logic                           prev_keep_i,
  output logic                           vld_o,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic [swm_pkg::IDX_W-1:0]      idx_o,
  output logic                           keep_o,
  output logic signed [SAMPLE_WIDTH-1:0] view_val_o
);
  import swm_pkg::*;

  logic                           vld_q, vld_d;
  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic                           view_vld;
  logic signed [SAMPLE_WIDTH-1:0] view_val;
  logic [IDX_W-1:0]               view_idx;
  logic                           keep;

  // entry as seen after the optional front pop and sequence clear
  assign view_vld = ~op_i.clear & (op_i.pop ? nb_vld_i : vld_q);
  assign view_val = op_i.pop ? nb_val_i : val_q;
  assign view_idx = op_i.pop ? nb_idx_i : idx_q;

  // entries larger than the new sample survive
  assign keep = view_vld & (view_val > sample_i);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    idx_d = idx_q;
    if (op_i.step) begin
      vld_d = keep | prev_keep_i;
      val_d = keep ? view_val : sample_i;
      idx_d = keep ? view_idx : idx_i;
    end else if (op_i.pop) begin
      vld_d = nb_vld_i;
      val_d = nb_val_i;
      idx_d = nb_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    idx_q <= idx_d;
  end

  assign vld_o      = vld_q;
  assign val_o      = val_q;
  assign idx_o      = idx_q;
  assign keep_o     = keep;
  assign view_val_o = view_val;

endmodule

// File: src/sliding_window_maximum_unit.sv
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+------------------------------
// in      | input     | in_valid_i / in_stall_o    | sample_i, first_sample_i
// out     | output    | out_valid_o / out_stall_i  | window_max_o
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_window_size_i
//
// one item per cycle in steady state while the output is not stalled; each extra front
// entry that has left the window at once (after the window was made smaller) is dropped while the item waits
// an item passes the input register, then a result leaves from the output register
// the candidate queue is a row of cells, front at cell 0, one shift per cycle at most
// reset empties the queue, clears the sample count and sets the window to 1
// a stalled output holds its result; the input register keeps taking items while free
module sliding_window_maximum_unit #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           first_sample_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o,
  // window size register
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]      cfg_window_size_i
);
  import swm_pkg::*;

  localparam int unsigned WIN_W = $clog2(WINDOW_MAX + 1);
  localparam logic [IDX_W:0] WMAX_EXT = (IDX_W + 1)'(WINDOW_MAX);

  // window register, stored already clamped to 1..WINDOW_MAX
  logic [WIN_W-1:0] win_q, win_d;
  logic [IDX_W:0]   cfg_ext;
  logic [IDX_W:0]   w_ext;

  // input holding register
  logic                           hold_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] hold_sample_q;
  logic                           hold_first_q;
  logic                           in_accept;

  // output register
  logic                           out_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] out_max_q;
  logic                           out_free;

  // sequence state
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             wrap_q, wrap_d;
  logic [IDX_W-1:0] idx_cur;
  logic             wrap_base;
  logic [IDX_W:0]   seen;
  logic             emit;

  // front expiry
  logic [IDX_W-1:0] age0, age1;
  logic             exp0, exp1;
  logic             pop_only;
  logic             consume;
  cell_op_t         op;

  // cell row
  logic [WINDOW_MAX-1:0]          c_vld;
  logic signed [SAMPLE_WIDTH-1:0] c_val [WINDOW_MAX];
  logic [IDX_W-1:0]               c_idx [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          c_keep;
  logic signed [SAMPLE_WIDTH-1:0] c_view [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] front_val;

  // ---------------------------------------------------------------------------
  // configuration, zero reads as one and large values saturate
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = (IDX_W + 1)'(cfg_window_size_i);

  always_comb begin
    priority if (cfg_ext == '0) begin
      win_d = WIN_W'(1);
    end else if (cfg_ext > WMAX_EXT) begin
      win_d = WIN_W'(WINDOW_MAX);
    end else begin
      win_d = WIN_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_q <= win_d;
    end
  end

  assign w_ext = (IDX_W + 1)'(win_q);

  // ---------------------------------------------------------------------------
  // front expiry check on the two front cells only, deeper stale entries reach them as the front drains
  // ---------------------------------------------------------------------------
  assign age0 = cnt_q - c_idx[0];
  assign age1 = cnt_q - c_idx[1];
  assign exp0 = c_vld[0] & ~hold_first_q & ({1'b0, age0} >= w_ext);
  assign exp1 = c_vld[1] & ~hold_first_q & ({1'b0, age1} >= w_ext);

  // two or more stale entries: drain one per cycle, item waits
  assign pop_only = hold_vld_q & exp0 & exp1;
  assign out_free = ~out_vld_q | ~out_stall_i;
  assign consume  = hold_vld_q & out_free & ~(exp0 & exp1);

  always_comb begin
    op.step  = consume;
    op.pop   = (consume & exp0) | pop_only;
    op.clear = consume & hold_first_q;
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  assign in_stall_o = hold_vld_q & ~consume;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else if (in_accept) begin
      hold_vld_q <= 1'b1;
    end else if (consume) begin
      hold_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hold_sample_q <= sample_i;
      hold_first_q  <= first_sample_i;
    end
  end

  // ---------------------------------------------------------------------------
  // sample count, wraps modulo 2^16; after a wrap the window counts as full
  // ---------------------------------------------------------------------------
  assign idx_cur   = hold_first_q ? '0 : cnt_q;
  assign wrap_base = hold_first_q ? 1'b0 : wrap_q;
  assign cnt_d     = idx_cur + IDX_W'(1);
  assign wrap_d    = wrap_base | (cnt_d == '0);
  assign seen      = {1'b0, idx_cur} + (IDX_W + 1)'(1);
  assign emit      = wrap_d | (seen >= w_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wrap_q <= 1'b0;
    end else if (consume) begin
      cnt_q  <= cnt_d;
      wrap_q <= wrap_d;
    end
  end

  // ---------------------------------------------------------------------------
  // candidate row, values fall strictly from cell 0 toward the back
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                           nb_vld;
    logic signed [SAMPLE_WIDTH-1:0] nb_val;
    logic [IDX_W-1:0]               nb_idx;
    logic                           prev_keep;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign nb_vld = 1'b0;
      assign nb_val = '0;
      assign nb_idx = '0;
    end else begin : g_mid
      assign nb_vld = c_vld[i+1];
      assign nb_val = c_val[i+1];
      assign nb_idx = c_idx[i+1];
    end

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_rest
      assign prev_keep = c_keep[i-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .sample_i    (hold_sample_q),
      .idx_i       (idx_cur),
      .nb_vld_i    (nb_vld),
      .nb_val_i    (nb_val),
      .nb_idx_i    (nb_idx),
      .prev_keep_i (prev_keep),
      .vld_o       (c_vld[i]),
      .val_o       (c_val[i]),
      .idx_o       (c_idx[i]),
      .keep_o      (c_keep[i]),
      .view_val_o  (c_view[i])
    );
  end

  // new front: the surviving front entry, or the new sample if nothing survives
  assign front_val = c_keep[0] ? c_view[0] : hold_sample_q;

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (consume && emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && emit) begin
      out_max_q <= front_val;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign window_max_o = out_max_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // occupied cells always form one block starting at the front
  a_vld_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_vld & (c_vld + WINDOW_MAX'(1))) == '0)
    else $error("queue has a hole");

  // survivors of the back drop form a block at the front
  a_keep_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.step |-> (c_keep & (c_keep + WINDOW_MAX'(1))) == '0)
    else $error("back drop left a hole");

  // a drain cycle leaves the item waiting
  a_pop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_only |=> hold_vld_q)
    else $error("item lost during front drain");

  // an emitted result shows up and carries the new front
  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && emit) |=> (out_vld_q && out_max_q == c_val[0]))
    else $error("result does not match queue front");

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = 16;
  localparam int DEPTH       = 64;
  // cycles to let pass before a window write, covers the pipeline plus a full expiry burst
  localparam int DRAIN       = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int BATCH       = 160;
  // window setting per random batch, -1 picks one at random
  localparam int WIN_PLAN [12] = '{64, 1, 127, 2, 0, 65, -1, 5, 64, 3, -1, 1};

  // predicts the window maximum of every accepted sample that yields a result and holds the pending ones
  class window_max_scoreboard;
    logic signed [SW-1:0] cand_value [DEPTH];
    logic [15:0]          cand_index [DEPTH];
    logic [5:0]           head;
    int                   depth;
    logic [15:0]          next_index;
    bit                   wrapped;
    logic [swm_pkg::CFG_W-1:0] window_size;
    logic signed [SW-1:0] expected_max_q [$];
    int                   errors;

    function new();
      head        = '0;
      depth       = 0;
      next_index  = '0;
      wrapped     = 1'b0;
      window_size = 7'd1;
      errors      = 0;
    endfunction

    function void set_window(logic [swm_pkg::CFG_W-1:0] value);
      window_size = value;
    endfunction

    function int pending();
      return expected_max_q.size();
    endfunction

    function void note_input(logic signed [SW-1:0] s, logic first);
      int          w;
      logic [15:0] idx;
      logic [15:0] age;
      logic [5:0]  pos;
      bit          busy;
      int          seen;
      w = window_size;
      if (w == 0) w = 1;
      if (w > DEPTH) w = DEPTH;
      if (first) begin
        head       = '0;
        depth      = 0;
        next_index = '0;
        wrapped    = 1'b0;
      end
      idx = next_index;
      // front entries that fell out of the window
      busy = 1'b1;
      while (depth > 0 && busy) begin
        age = idx - cand_index[head];
        if (age >= w) begin
          head  = head + 6'd1;
          depth = depth - 1;
        end else begin
          busy = 1'b0;
        end
      end
      // back entries no greater than the new sample
      busy = 1'b1;
      while (depth > 0 && busy) begin
        pos = head + 6'(depth - 1);
        if (cand_value[pos] <= s) depth = depth - 1;
        else busy = 1'b0;
      end
      if (depth >= DEPTH) begin
        head  = head + 6'd1;
        depth = depth - 1;
      end
      pos = head + 6'(depth);
      cand_value[pos] = s;
      cand_index[pos] = idx;
      depth = depth + 1;
      seen = int'(idx) + 1;
      next_index = idx + 16'd1;
      if (next_index == 16'd0) wrapped = 1'b1;
      if (wrapped || seen >= w) expected_max_q = {expected_max_q, cand_value[head]};
    endfunction

    function void check_result(logic signed [SW-1:0] actual);
      logic signed [SW-1:0] exp_max;
      if (expected_max_q.size() == 0) begin
        $error("window_max: no result expected, actual %0d", actual);
        errors++;
      end else begin
        exp_max = expected_max_q[0];
        expected_max_q.delete(0);
        if (actual !== exp_max) begin
          $error("window_max: expected %0d, actual %0d", exp_max, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic                      clk_i             = 1'b0;
  logic                      rst_ni            = 1'b0;
  logic                      in_valid_i        = 1'b0;
  logic                      in_stall_o;
  logic signed [SW-1:0]      sample_i          = '0;
  logic                      first_sample_i    = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i       = 1'b0;
  logic signed [SW-1:0]      window_max_o;
  logic                      cfg_valid_i       = 1'b0;
  logic                      cfg_ready_o;
  logic [swm_pkg::CFG_W-1:0] cfg_window_size_i = '0;

  window_max_scoreboard sb;

  // idle rates in percent, set per phase by the stimulus
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long receiver hold-offs: the stimulus bumps the request count, the receiver serves it
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  // state of the sequence being sent, kept across batches
  int seq_left    = 0;
  int seq_pattern = 0;
  int seq_level   = 0;

  sliding_window_maximum_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .first_sample_i    (first_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .window_max_o      (window_max_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_size_i (cfg_window_size_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sliding_window_maximum_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_reqs != hold_served) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (int'($urandom_range(99)) < recv_idle_pct);
    end
  end

  // watch both channels; an input is noted before a result is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(sample_i, first_sample_i);
      if (out_valid_o && !out_stall_i) sb.check_result(window_max_o);
    end
  end

  function automatic int eff_window(int w);
    if (w == 0) return 1;
    if (w > DEPTH) return DEPTH;
    return w;
  endfunction

  // one sample item; called at a rising edge, returns at the edge that accepts it
  task automatic send_item(input logic signed [SW-1:0] s, input logic first);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_i       <= s;
    first_sample_i <= first;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    @(posedge clk_i);
  endtask

  // window write, only with the block idle
  task automatic write_window(input int value);
    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_window_size_i <= value[swm_pkg::CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_window(value[swm_pkg::CFG_W-1:0]);
  endtask

  // sample shapes: full random, narrow range with ties, falling, rising, extremes only
  function automatic logic signed [SW-1:0] next_sample();
    case (seq_pattern)
      0: return SW'($urandom);
      1: return SW'(int'($urandom_range(8)) - 4);
      2: begin
        seq_level = seq_level - int'($urandom_range(3));
        if (seq_level < -32768) seq_level = 32767;
        return SW'(seq_level);
      end
      3: begin
        seq_level = seq_level + int'($urandom_range(3));
        if (seq_level > 32767) seq_level = -32768;
        return SW'(seq_level);
      end
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic void start_sequence(int w);
    if ($urandom_range(9) < 7) seq_left = $urandom_range(3 * w + 2, 1);
    else seq_left = $urandom_range(8, 1);
    seq_pattern = $urandom_range(4);
    seq_level   = int'($urandom_range(65535)) - 32768;
  endfunction

  // mostly whole sequences with random content, some stray first-sample flags
  task automatic send_batch(input int n_items, input int w, input int pause_at);
    logic first;
    int   i;
    if ($urandom_range(1)) seq_left = 0;
    for (i = 0; i < n_items; i++) begin
      if (i == pause_at) wait_drained();
      first = 1'b0;
      if (seq_left == 0) begin
        start_sequence(w);
        first = 1'b1;
      end else if ($urandom_range(99) < 8) begin
        first = 1'($urandom_range(1));
      end
      seq_left = seq_left - 1;
      send_item(next_sample(), first);
    end
  endtask

  initial begin
    int mode;
    int k;
    int w;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window at its reset value of one: every sample is its own maximum
    send_item(16'sh7fff, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(-16'sd1,   1'b0);
    // window size zero acts as one
    write_window(0);
    send_item(16'sd5,  1'b1);
    send_item(-16'sd5, 1'b0);
    // size above the limit saturates; falling run leaves the window unfilled
    write_window(127);
    send_item(16'sd100,  1'b1);
    send_item(16'sd50,   1'b0);
    send_item(-16'sd50,  1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh8000, 1'b0);
    // shrink mid-sequence: several front entries expire at once, ties drop from the back
    write_window(3);
    send_item(16'sd7, 1'b0);
    send_item(16'sd7, 1'b0);
    send_item(16'sd1, 1'b0);
    // growth mid-sequence: expired entries stay lost
    write_window(6);
    send_item(-16'sd2, 1'b0);
    send_item(-16'sd3, 1'b0);
    send_item(16'sd4,  1'b0);
    // restart with a short window
    write_window(2);
    send_item(16'sd9,    1'b1);
    send_item(16'sd9,    1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7fff, 1'b0);

    // random part: sender idles / receiver idles, then swapped, then no idling
    for (mode = 0; mode < 3; mode++) begin
      for (k = 0; k < 4; k++) begin
        w = WIN_PLAN[mode * 4 + k];
        if (w < 0) w = $urandom_range(DEPTH, 1);
        write_window(w);
        send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 81 : 0;
        recv_idle_pct = (mode == 0) ? 81 : (mode == 1) ? 29 : 0;
        // long receiver hold-off with the sender still pushing, so the input backs up
        if (mode == 2 && k == 1) hold_reqs = hold_reqs + 1;
        // one sender pause until everything has drained
        send_batch(BATCH, eff_window(w), (mode == 1 && k == 2) ? BATCH / 2 : -1);
      end
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[sliding_window_maximum_unit] OK");
    end else begin
      $display("[sliding_window_maximum_unit] ERROR");
    end
    $finish;
  end

endmodule
